[rtl/core/udrb_pkg.sv]
// ----------------------------------------------------------------------------
// udrb_pkg
// shared types and codes of the dual serial ring buffer
// ----------------------------------------------------------------------------
`default_nettype none

package udrb_pkg;

  // request codes
  localparam logic [1:0] MODE_SW_SEND  = 2'd0;
  localparam logic [1:0] MODE_SW_RECV  = 2'd1;
  localparam logic [1:0] MODE_TX_READY = 2'd2;
  localparam logic [1:0] MODE_LINE_RX  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_TX_FULL     = 2'd1;
  localparam logic [1:0] ST_RX_EMPTY    = 2'd2;
  localparam logic [1:0] ST_RX_OVERFLOW = 2'd3;

  localparam int unsigned FILL_W = 7;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] byte_in;
  } udrb_req_t;

  typedef struct packed {
    logic [7:0]        byte_out;
    logic              byte_valid;
    logic [1:0]        status;
    logic              tx_irq_enable;
    logic [FILL_W-1:0] tx_fill;
    logic [FILL_W-1:0] rx_fill;
  } udrb_rsp_t;

endpackage

`default_nettype wire

[rtl/core/uart_dual_ring_buffer_core.sv]
// ----------------------------------------------------------------------------
// uart_dual_ring_buffer_core
// transmit and receive byte rings for an interrupt driven serial port
// ----------------------------------------------------------------------------
// usage
//   a request (in_req.mode, in_req.byte_in) is taken at a rising edge with
//   start high and busy low; busy stays low, so a request may come every cycle
//   mode software send pushes into the transmit ring and sets the irq enable, unless that ring is full
//   mode software receive pops the receive ring
//   mode transmitter ready pops the transmit ring, or clears the irq enable
//   when that ring is empty
//   mode line byte pushes into the receive ring, dropping it when full
// latency and throughput
//   one response per request, shown on out_rsp for exactly one cycle with
//   out_valid high, the cycle after the request edge; one request per cycle,
//   set by the single ring memory read per request
// reset
//   synchronous active-low rst_n empties both rings and clears the irq enable;
//   ring contents are not cleared, only written entries are ever popped
// the receiver cannot stall; each response must be taken when out_valid is high
// ----------------------------------------------------------------------------
`default_nettype none

module uart_dual_ring_buffer_core import udrb_pkg::*; #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire udrb_req_t in_req,
  output logic           out_valid,
  output udrb_rsp_t      out_rsp
);

  logic              accept;
  logic              tx_push, tx_pop, rx_push, rx_pop;
  logic              tx_full, tx_empty, rx_full, rx_empty;
  logic [7:0]        tx_rdata, rx_rdata;
  logic [FILL_W-1:0] tx_fill, rx_fill;

  logic       valid_r;
  logic       popped_r, popped_nxt;
  logic       from_tx_r, from_tx_nxt;
  logic [1:0] status_r, status_nxt;
  logic       irq_r, irq_nxt;

  // every request is done within its edge, so no request is ever held off
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ring operations, each fired right at the request edge
  assign tx_push = accept && (in_req.mode == MODE_SW_SEND)  && !tx_full;
  assign tx_pop  = accept && (in_req.mode == MODE_TX_READY) && !tx_empty;
  assign rx_push = accept && (in_req.mode == MODE_LINE_RX)  && !rx_full;
  assign rx_pop  = accept && (in_req.mode == MODE_SW_RECV)  && !rx_empty;

  udrb_ring #(.RING_DEPTH(RING_DEPTH)) u_tx_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (tx_push),
    .pop   (tx_pop),
    .wdata (in_req.byte_in),
    .rdata (tx_rdata),
    .full  (tx_full),
    .empty (tx_empty),
    .fill  (tx_fill)
  );

  udrb_ring #(.RING_DEPTH(RING_DEPTH)) u_rx_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rx_push),
    .pop   (rx_pop),
    .wdata (in_req.byte_in),
    .rdata (rx_rdata),
    .full  (rx_full),
    .empty (rx_empty),
    .fill  (rx_fill)
  );

  // status, irq enable and which ring answers
  always_comb begin
    status_nxt  = status_r;
    irq_nxt     = irq_r;
    popped_nxt  = popped_r;
    from_tx_nxt = from_tx_r;
    if (accept) begin
      status_nxt  = ST_OK;
      popped_nxt  = tx_pop || rx_pop;
      from_tx_nxt = tx_pop;
      case (in_req.mode)
        MODE_SW_SEND: begin
          if (tx_full) status_nxt = ST_TX_FULL;
          else         irq_nxt    = 1'b1;
        end
        MODE_SW_RECV: begin
          if (rx_empty) status_nxt = ST_RX_EMPTY;
        end
        MODE_TX_READY: begin
          if (tx_empty) irq_nxt = 1'b0;
        end
        MODE_LINE_RX: begin
          if (rx_full) status_nxt = ST_RX_OVERFLOW;
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      irq_r     <= 1'b0;
      popped_r  <= 1'b0;
      from_tx_r <= 1'b0;
      status_r  <= ST_OK;
    end else begin
      valid_r   <= accept;
      irq_r     <= irq_nxt;
      popped_r  <= popped_nxt;
      from_tx_r <= from_tx_nxt;
      status_r  <= status_nxt;
    end
  end

  // response: memory read data lands the cycle after the request edge,
  // fill counts and irq enable already hold their post-request values
  assign out_valid             = valid_r;
  assign out_rsp.byte_out      = popped_r ? (from_tx_r ? tx_rdata : rx_rdata) : 8'd0;
  assign out_rsp.byte_valid    = popped_r;
  assign out_rsp.status        = status_r;
  assign out_rsp.tx_irq_enable = irq_r;
  assign out_rsp.tx_fill       = tx_fill;
  assign out_rsp.rx_fill       = rx_fill;

endmodule

`default_nettype wire

[rtl/core/udrb_ring.sv]
// ----------------------------------------------------------------------------
// udrb_ring
// one byte ring: synchronous memory, wrapping indices and fill count
// ----------------------------------------------------------------------------
`default_nettype none

module udrb_ring import udrb_pkg::*; #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic              pop,
  input  wire logic [7:0]        wdata,
  output logic      [7:0]        rdata,
  output logic                   full,
  output logic                   empty,
  output logic      [FILL_W-1:0] fill
);

  localparam int unsigned IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(RING_DEPTH);

  logic [7:0]       mem [RING_DEPTH];
  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       rdata_r;

  assign full  = (cnt_r == DEPTH_CNT);
  assign empty = (cnt_r == '0);
  assign rdata = rdata_r;

  generate
    if (CNT_W >= FILL_W) begin : g_fill_trunc
      assign fill = cnt_r[FILL_W-1:0];
    end else begin : g_fill_ext
      assign fill = {{(FILL_W - CNT_W){1'b0}}, cnt_r};
    end
  endgenerate

  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_idx_nxt = (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + IDX_W'(1);
      cnt_nxt    = cnt_r + CNT_W'(1);
    end else if (pop) begin
      rd_idx_nxt = (rd_idx_r == LAST_IDX) ? '0 : rd_idx_r + IDX_W'(1);
      cnt_nxt    = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_idx_r] <= wdata;
    end
    if (pop) begin
      rdata_r <= mem[rd_idx_r];
    end
  end

endmodule

`default_nettype wire
